>>> rtl/efp_pkg.sv
// Shared types and constants for the escape-time fractal pixel block.
package efp_pkg;

    localparam int IN_W       = 10;   // column / row field width
    localparam int CNT_W      = 16;   // iteration count, colour scale registers
    localparam int COL_W      = 16;   // RGB565 word
    localparam int ORG_W      = 40;   // x_left / y_start, signed Q4.36
    localparam int STEP_W     = 37;   // step_x / step_y, unsigned Q1.36
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 56;
    localparam int CH_W       = 8;    // one colour channel before packing
    localparam int NUM_W      = 24;   // channel numerator, x * 255

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LEFT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_START     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y      = 3'd5;

    localparam logic [CNT_W-1:0]  MAX_ITER_RST    = 16'd300;
    localparam logic [CNT_W-1:0]  COLOR_FLOOR_RST = 16'd37;
    localparam logic [ORG_W-1:0]  X_LEFT_RST      = 40'hD8_0000_0000;  // -2.5
    localparam logic [ORG_W-1:0]  Y_START_RST     = 40'hE8_0000_0000;  // -1.5
    localparam logic [STEP_W-1:0] STEP_X_RST      = 37'd861686228;
    localparam logic [STEP_W-1:0] STEP_Y_RST      = 37'd862587574;

    // Control for one partial-product multiplier lane
    typedef struct packed {
        logic       clr;
        logic       mul_en;
        logic [1:0] mul_k;
        logic       acc_en;
        logic [1:0] acc_k;
        logic       fin;
    } t_mul_cmd;

    typedef struct packed {
        logic       load_in;
        logic       c_mul;
        logic       c_add;
        logic       mag;
        t_mul_cmd   mul;
        logic       upd;
        logic       col_set;
        logic       div_en;
        logic [2:0] div_k;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic n_lt_max;
        logic escape;
    } t_sts;

endpackage

>>> rtl/efp_mul_lane.sv
// Signed fixed-point multiplier lane: four half-width partial products, then scale and saturate.
module efp_mul_lane #(
    parameter int FRAC_BITS = 36
) (
    input  logic                                 i_clk,
    input  efp_pkg::t_mul_cmd                    i_cmd,
    input  logic [2*((FRAC_BITS+5)/2)-1:0]       i_a,    // magnitude
    input  logic [2*((FRAC_BITS+5)/2)-1:0]       i_b,    // magnitude
    input  logic                                 i_neg,
    output logic [FRAC_BITS+3:0]                 o_q     // signed Q4 result
);
    import efp_pkg::*;

    localparam int W  = FRAC_BITS + 4;
    localparam int H  = (W + 1) / 2;
    localparam int AW = 4 * H;
    localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

    logic [2*H-1:0] r_pp;
    logic [AW-1:0]  r_acc;
    logic [W-1:0]   r_q;

    logic [H-1:0]   a_half;
    logic [H-1:0]   b_half;
    logic [AW-1:0]  pp_ext;
    logic           over;
    logic [W-2:0]   q_mag;
    logic [W-1:0]   n_q;

    always_comb begin
        a_half = i_cmd.mul_k[1] ? i_a[2*H-1:H] : i_a[H-1:0];
        b_half = i_cmd.mul_k[0] ? i_b[2*H-1:H] : i_b[H-1:0];
        unique case (i_cmd.acc_k)
            2'd0:    pp_ext = AW'(r_pp);
            2'd3:    pp_ext = AW'(r_pp) << (2 * H);
            default: pp_ext = AW'(r_pp) << H;
        endcase
    end

    // truncate toward zero on the magnitude, saturate past the Q4 range
    always_comb begin
        over  = |(r_acc >> (FRAC_BITS + W - 1));
        q_mag = r_acc[FRAC_BITS+W-2:FRAC_BITS];
        if (over) begin
            n_q = i_neg ? QMIN : QMAX;
        end else begin
            n_q = i_neg ? ({W{1'b0}} - {1'b0, q_mag}) : {1'b0, q_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pp <= a_half * b_half;
        end
        if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + pp_ext;
        end
        if (i_cmd.fin) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/efp_ctrl.sv
// Sequencer for the escape-time pixel: coordinate setup, iteration loop, colour divide, output.
module efp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  efp_pkg::t_sts i_sts,
    output efp_pkg::t_cmd o_cmd
);
    import efp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CMUL = 4'd1;
    localparam logic [3:0] S_CADD = 4'd2;
    localparam logic [3:0] S_MAG  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_UPD  = 4'd6;
    localparam logic [3:0] S_CSET = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [2:0] MUL_LAST = 3'd4;  // four products, one drain into the accumulator
    localparam logic [2:0] DIV_LAST = 3'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_step;
    logic [2:0] n_step;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CMUL;
                end
            end
            S_CMUL: begin
                o_cmd.c_mul = 1'b1;
                n_state     = S_CADD;
            end
            S_CADD: begin
                o_cmd.c_add = 1'b1;
                n_state     = S_MAG;
            end
            S_MAG: begin
                if (i_sts.n_lt_max) begin
                    o_cmd.mag     = 1'b1;
                    o_cmd.mul.clr = 1'b1;
                    n_step        = '0;
                    n_state       = S_MUL;
                end else begin
                    n_state = S_CSET;
                end
            end
            S_MUL: begin
                o_cmd.mul.mul_en = !r_step[2];
                o_cmd.mul.mul_k  = r_step[1:0];
                o_cmd.mul.acc_en = (r_step != '0);
                o_cmd.mul.acc_k  = r_step[1:0] - 2'd1;
                if (r_step == MUL_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_FIN: begin
                o_cmd.mul.fin = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                if (i_sts.escape) begin
                    n_state = S_CSET;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_MAG;
                end
            end
            S_CSET: begin
                o_cmd.col_set = 1'b1;
                n_step        = '0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                o_cmd.div_k  = DIV_LAST - r_step;
                if (r_step == DIV_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_CMUL))
        else $error("accepted pixel did not start coordinate setup");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_tready)
            |=> (r_state == S_OUT && r_out_valid))
        else $error("finished pixel lost while output stalled");

endmodule

>>> rtl/efp_dp.sv
// Datapath: config registers, c setup, z iteration with three multiplier lanes, jet colour divide.
module efp_dp #(
    parameter int FRAC_BITS  = 36,
    parameter int COORD_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [efp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [efp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [efp_pkg::S_TDATA_W-1:0]      i_tdata,
    input  efp_pkg::t_cmd                      i_cmd,
    output efp_pkg::t_sts                      o_sts,
    output logic [efp_pkg::M_TDATA_W-1:0]      o_tdata
);
    import efp_pkg::*;

    localparam int W   = FRAC_BITS + 4;
    localparam int H   = (W + 1) / 2;
    localparam int CW  = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
    localparam int PW  = CW + STEP_W;
    localparam int SW  = ((W > PW + 1) ? W : PW + 1) + 2;
    localparam int PAD = M_TDATA_W - 2 * IN_W - CNT_W - COL_W;

    localparam logic [W-1:0]  QMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  QMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] SQMAX = {{(SW-W){1'b0}}, QMAX};
    localparam logic signed [SW-1:0] SQMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W:0]    FOUR  = {{(W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

    localparam logic [1:0] BAND_BLUE   = 2'd0;  // blue to cyan
    localparam logic [1:0] BAND_CYAN   = 2'd1;  // cyan to green
    localparam logic [1:0] BAND_GREEN  = 2'd2;  // green to yellow
    localparam logic [1:0] BAND_YELLOW = 2'd3;  // yellow to red

    function automatic logic [W-1:0] sat(input logic signed [SW-1:0] x);
        if (x > SQMAX) begin
            sat = QMAX;
        end else if (x < SQMIN) begin
            sat = QMIN;
        end else begin
            sat = x[W-1:0];
        end
    endfunction

    // configuration
    logic [CNT_W-1:0]  r_max_iter;
    logic [CNT_W-1:0]  r_color_floor;
    logic [ORG_W-1:0]  r_x_left;
    logic [ORG_W-1:0]  r_y_start;
    logic [STEP_W-1:0] r_step_x;
    logic [STEP_W-1:0] r_step_y;

    // pixel and iteration state
    logic [CW-1:0]     r_col;
    logic [CW-1:0]     r_row;
    logic [PW-1:0]     r_px;
    logic [PW-1:0]     r_py;
    logic [W-1:0]      r_cr;
    logic [W-1:0]      r_ci;
    logic [W-1:0]      r_zr;
    logic [W-1:0]      r_zi;
    logic [2*H-1:0]    r_ua_r;
    logic [2*H-1:0]    r_ua_i;
    logic              r_neg_ri;
    logic [CNT_W-1:0]  r_n;

    // colour
    logic [CNT_W-1:0]  r_d;
    logic [NUM_W-1:0]  r_rem;
    logic [CH_W-1:0]   r_quo;
    logic [1:0]        r_band;
    logic              r_black;
    logic [M_TDATA_W-1:0] r_tdata;

    logic [W-1:0]      r2;
    logic [W-1:0]      i2;
    logic [W-1:0]      ri;

    logic signed [SW-1:0] sum_cr;
    logic signed [SW-1:0] sum_ci;
    logic signed [SW-1:0] sum_zr;
    logic signed [SW-1:0] sum_zi;
    logic [W-1:0]      zr_mag;
    logic [W-1:0]      zi_mag;

    logic [CNT_W-1:0]  v_clamp;
    logic [CNT_W-1:0]  t_span;
    logic [CNT_W+1:0]  t4;
    logic [CNT_W+1:0]  d1;
    logic [CNT_W+1:0]  d2;
    logic [CNT_W+1:0]  d3;
    logic [CNT_W+1:0]  d4;
    logic [CNT_W+1:0]  x_num;
    logic [1:0]        band;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  d_shift;
    logic [CH_W-1:0]   ch_r;
    logic [CH_W-1:0]   ch_g;
    logic [CH_W-1:0]   ch_b;
    logic [COL_W-1:0]  colour;

    efp_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_rr (
        .i_clk (i_clk),
        .i_cmd (i_cmd.mul),
        .i_a   (r_ua_r),
        .i_b   (r_ua_r),
        .i_neg (1'b0),
        .o_q   (r2)
    );

    efp_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_ii (
        .i_clk (i_clk),
        .i_cmd (i_cmd.mul),
        .i_a   (r_ua_i),
        .i_b   (r_ua_i),
        .i_neg (1'b0),
        .o_q   (i2)
    );

    efp_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_ri (
        .i_clk (i_clk),
        .i_cmd (i_cmd.mul),
        .i_a   (r_ua_r),
        .i_b   (r_ua_i),
        .i_neg (r_neg_ri),
        .o_q   (ri)
    );

    always_comb begin
        sum_cr = SW'($signed(r_x_left)) + $signed(SW'(r_px));
        sum_ci = SW'($signed(r_y_start)) + $signed(SW'(r_py));
        sum_zr = SW'($signed(r2)) - SW'($signed(i2)) + SW'($signed(r_cr));
        sum_zi = (SW'($signed(ri)) <<< 1) + SW'($signed(r_ci));
        zr_mag = r_zr[W-1] ? ({W{1'b0}} - r_zr) : r_zr;
        zi_mag = r_zi[W-1] ? ({W{1'b0}} - r_zi) : r_zi;
    end

    assign o_sts.n_lt_max = (r_n < r_max_iter);
    assign o_sts.escape   = (({1'b0, r2} + {1'b0, i2}) > FOUR);

    // band and numerator of the one channel that ramps
    always_comb begin
        if (r_n < r_color_floor) begin
            v_clamp = r_color_floor;
        end else if (r_n > r_max_iter) begin
            v_clamp = r_max_iter;
        end else begin
            v_clamp = r_n;
        end
        t_span = v_clamp - r_color_floor;
        t4     = {t_span, 2'b00};
        d1     = {2'b00, r_max_iter - r_color_floor};
        d2     = d1 << 1;
        d3     = d2 + d1;
        d4     = d1 << 2;
        priority if (t4 < d1) begin
            band  = BAND_BLUE;
            x_num = t4;
        end else if (t4 < d2) begin
            band  = BAND_CYAN;
            x_num = d2 - t4;
        end else if (t4 < d3) begin
            band  = BAND_GREEN;
            x_num = t4 - d2;
        end else begin
            band  = BAND_YELLOW;
            x_num = d4 - t4;
        end
        num = {x_num[CNT_W-1:0], 8'b0} - {8'b0, x_num[CNT_W-1:0]};
    end

    assign d_shift = {{(NUM_W-CNT_W){1'b0}}, r_d} << i_cmd.div_k;

    always_comb begin
        unique case (r_band)
            BAND_BLUE: begin
                ch_r = '0;
                ch_g = r_quo;
                ch_b = '1;
            end
            BAND_CYAN: begin
                ch_r = '0;
                ch_g = '1;
                ch_b = r_quo;
            end
            BAND_GREEN: begin
                ch_r = r_quo;
                ch_g = '1;
                ch_b = '0;
            end
            BAND_YELLOW: begin
                ch_r = '1;
                ch_g = r_quo;
                ch_b = '0;
            end
            default: begin
                ch_r = '0;
                ch_g = '0;
                ch_b = '0;
            end
        endcase
        colour = r_black ? '0 : {ch_r[7:3], ch_g[7:2], ch_b[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter    <= MAX_ITER_RST;
            r_color_floor <= COLOR_FLOOR_RST;
            r_x_left      <= X_LEFT_RST;
            r_y_start     <= Y_START_RST;
            r_step_x      <= STEP_X_RST;
            r_step_y      <= STEP_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_ITER:    r_max_iter    <= i_cfg_data[CNT_W-1:0];
                CFG_COLOR_FLOOR: r_color_floor <= i_cfg_data[CNT_W-1:0];
                CFG_X_LEFT:      r_x_left      <= i_cfg_data[ORG_W-1:0];
                CFG_Y_START:     r_y_start     <= i_cfg_data[ORG_W-1:0];
                CFG_STEP_X:      r_step_x      <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:      r_step_y      <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_tdata[CW-1:0];
            r_row <= i_tdata[IN_W+CW-1:IN_W];
        end
        if (i_cmd.c_mul) begin
            r_px <= PW'(r_col * r_step_x);
            r_py <= PW'(r_row * r_step_y);
        end
        if (i_cmd.c_add) begin
            r_cr <= sat(sum_cr);
            r_ci <= sat(sum_ci);
            r_zr <= '0;
            r_zi <= '0;
            r_n  <= '0;
        end else if (i_cmd.upd) begin
            r_zr <= sat(sum_zr);
            r_zi <= sat(sum_zi);
            r_n  <= r_n + CNT_W'(1);
        end
        if (i_cmd.mag) begin
            r_ua_r   <= (2*H)'(zr_mag);
            r_ua_i   <= (2*H)'(zi_mag);
            r_neg_ri <= r_zr[W-1] ^ r_zi[W-1];
        end
        // restoring divide, one quotient bit per cycle, top bit first
        if (i_cmd.col_set) begin
            r_d     <= d1[CNT_W-1:0];
            r_rem   <= num;
            r_quo   <= '0;
            r_band  <= band;
            r_black <= (r_max_iter <= r_color_floor);
        end else if (i_cmd.div_en) begin
            if (r_rem >= d_shift) begin
                r_rem               <= r_rem - d_shift;
                r_quo[i_cmd.div_k]  <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_tdata <= {{PAD{1'b0}}, colour, r_n, IN_W'(r_row), IN_W'(r_col)};
        end
    end

    assign o_tdata = r_tdata;

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> (r_n == $past(r_n) + CNT_W'(1)))
        else $error("iteration count did not advance by one");

    a_squares_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |-> (!r2[W-1] && !i2[W-1]))
        else $error("squared term came out negative");

    a_div_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_black || (r_rem < {{(NUM_W-CNT_W){1'b0}}, r_d})))
        else $error("colour divide left remainder not below divisor");

endmodule

>>> rtl/escape_time_fractal_pixel.sv
// Three lanes share the iteration loop, each building a product from four half-width
// partial products; the colour channel takes a restoring divide.
// One pixel at a time; the next input is taken the cycle after the result is registered.
// Synchronous active-low reset clears control state and restores the register defaults.
module escape_time_fractal_pixel #(
    parameter int FRAC_BITS  = 36,
    parameter int COORD_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [efp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [efp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [efp_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // column[9:0], row[19:10]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [efp_pkg::M_TDATA_W-1:0]   m_axis_tdata    // out_column[9:0], out_row[19:10],
                                                            // iteration_count[35:20],
                                                            // pixel_color[51:36]
);
    import efp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    efp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    efp_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_tdata     (m_axis_tdata)
    );

endmodule
